/* rtl/fspa_pkg.sv */
// Shared types, constants and codes of the fixed slot pool allocator.
package fspa_pkg;

	localparam int NUM_PARTS  = 16;
	localparam int MAX_SLOTS  = 1024;
	localparam int PART_BYTES = 4096;
	localparam int PART_W     = $clog2(NUM_PARTS);
	localparam int SLOT_W     = $clog2(MAX_SLOTS);
	localparam int CNT_W      = SLOT_W + 1;
	localparam int RAM_W      = CNT_W + 1;
	localparam int RAM_DEPTH  = NUM_PARTS * MAX_SLOTS;
	localparam int OFF_W      = $clog2(PART_BYTES);
	localparam int SIZE_W     = 13;
	localparam int POOL_W     = 15;
	localparam int DIV_CNT_W  = $clog2(OFF_W);

	localparam logic [1:0] ACT_ALLOC   = 2'd0;
	localparam logic [1:0] ACT_FREE    = 2'd1;
	localparam logic [1:0] ACT_COMPACT = 2'd2;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_SPACE    = 3'd1;
	localparam logic [2:0] ST_NOT_IN_POOL = 3'd2;
	localparam logic [2:0] ST_MISALIGNED  = 3'd3;
	localparam logic [2:0] ST_DOUBLE_FREE = 3'd4;

	localparam logic [1:0] L_UNUSED  = 2'd0;
	localparam logic [1:0] L_EMPTY   = 2'd1;
	localparam logic [1:0] L_PARTIAL = 2'd2;
	localparam logic [1:0] L_FULL    = 2'd3;

	localparam logic [1:0] CFG_SLOT_SIZE  = 2'd0;
	localparam logic [1:0] CFG_FIRST_SLOT = 2'd1;
	localparam logic [1:0] CFG_SLOTS      = 2'd2;

	typedef struct packed {
		logic [1:0]        action;
		logic [PART_W-1:0] part_index;
		logic [OFF_W-1:0]  byte_offset;
	} cmd_t;

	typedef struct packed {
		logic [2:0]        status;
		logic [PART_W-1:0] given_part;
		logic [OFF_W-1:0]  given_offset;
		logic [POOL_W-1:0] free_slots;
		logic [POOL_W-1:0] total_slots;
	} rsp_t;

	typedef struct packed {
		logic              start;
		logic [OFF_W-1:0]  dividend;
		logic [SIZE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [OFF_W-1:0]  quot;
		logic [SIZE_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_CLAIM,
		S_AREAD,
		S_ACOMMIT,
		S_DIV,
		S_FREAD,
		S_FCOMMIT,
		S_COMPACT,
		S_RESP
	} state_t;

endpackage

/* rtl/fspa_ram.sv */
// Generic single-port RAM with registered read.
module fspa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

/* rtl/fspa_div.sv */
// Restoring divider, one quotient bit per cycle, for slot offset decode.
module fspa_div (
	input  logic               clk,
	input  logic               arst_n,
	input  fspa_pkg::div_req_t req,
	output fspa_pkg::div_rsp_t rsp
);

	logic                            run_q;
	logic                            done_q;
	logic [fspa_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [fspa_pkg::OFF_W-1:0]      quo_q;
	logic [fspa_pkg::SIZE_W-1:0]     rem_q;
	logic [fspa_pkg::SIZE_W-1:0]     dsr_q;
	logic [fspa_pkg::SIZE_W-1:0]     trial;
	logic                            ge;

	// remainder never exceeds the 12-bit dividend, so its top bit is always zero
	assign trial = {rem_q[fspa_pkg::SIZE_W-2:0], quo_q[fspa_pkg::OFF_W-1]};
	assign ge    = trial >= dsr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= fspa_pkg::DIV_CNT_W'(fspa_pkg::OFF_W - 1);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dsr_q <= req.divisor;
		end else if (run_q) begin
			rem_q <= ge ? trial - dsr_q : trial;
			quo_q <= {quo_q[fspa_pkg::OFF_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

endmodule

/* rtl/fixed_slot_pool_allocator_top.sv */
// Top level of the fixed slot pool allocator: sequencer, part lists and slot RAM.
//
// Usage: drive cmd and pulse start while busy is low; the transfer happens at
// that edge. Actions: allocate, free (part_index, byte_offset), compact.
// Each command gives exactly one result: done is high for one cycle with rsp
// valid; the receiver cannot hold it off.
// Sequence: allocate from a listed part reads and then writes the slot RAM;
// allocate that claims an unused part first builds its free stack in the slot
// RAM, one slot per cycle. Free first waits on the serial offset divider (12
// quotient bits, one a cycle, then its done flag); early errors skip straight
// to the result. Compact walks all parts, one a cycle. Single-port slot RAM
// read-modify-write sets the allocate/free rate.
// Configuration: cfg_we writes cfg_data to register cfg_index at once; write
// only while busy is low and no result is pending.
// Reset: all parts unused, lists empty, counts zero; registers return to
// slot_size 16, first_slot_offset 16, slots_in_part 255. No RAM clearing.
module fixed_slot_pool_allocator_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  fspa_pkg::cmd_t              cmd,
	output logic                        done,
	output fspa_pkg::rsp_t              rsp,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [fspa_pkg::SIZE_W-1:0] cfg_data
);

	localparam int RAM_AW = $clog2(fspa_pkg::RAM_DEPTH);

	fspa_pkg::state_t state_q, state_d;
	fspa_pkg::cmd_t   cmd_q;
	fspa_pkg::rsp_t   rsp_q;
	logic             done_q;

	logic [fspa_pkg::SIZE_W-1:0] slot_size_q;
	logic [fspa_pkg::OFF_W-1:0]  fso_q;
	logic [fspa_pkg::CNT_W-1:0]  sip_q;

	logic [1:0]                  plist_q [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::PART_W-1:0] link_q  [fspa_pkg::NUM_PARTS];
	logic                        lv_q    [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::PART_W-1:0] heads_q [3];
	logic [2:0]                  hv_q;
	logic [fspa_pkg::CNT_W-1:0]  fc_q    [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::CNT_W-1:0]  cap_q   [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::CNT_W-1:0]  fsh_q   [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::POOL_W-1:0] pool_free_q;
	logic [fspa_pkg::POOL_W-1:0] pool_total_q;

	logic [1:0]                  plist_n [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::PART_W-1:0] link_n  [fspa_pkg::NUM_PARTS];
	logic                        lv_n    [fspa_pkg::NUM_PARTS];
	logic [fspa_pkg::PART_W-1:0] heads_n [3];
	logic [2:0]                  hv_n;
	logic [1:0]                  l0;

	logic [fspa_pkg::PART_W-1:0] part_q;
	logic [fspa_pkg::SLOT_W-1:0] slot_q;
	logic [fspa_pkg::CNT_W-1:0]  sweep_q;
	logic [2:0]                  status_q;
	logic [fspa_pkg::PART_W-1:0] gpart_q;
	logic [fspa_pkg::OFF_W-1:0]  goff_q;

	logic [fspa_pkg::SIZE_W-1:0] eff_size;
	logic [fspa_pkg::CNT_W-1:0]  eff_cap;
	logic                        found;
	logic [fspa_pkg::PART_W-1:0] claim_p;
	logic [1:0]                  cur_list;
	logic [fspa_pkg::CNT_W-1:0]  cur_fc, cur_cap, cur_fsh, fc_dec, fc_inc;
	logic                        not_in_pool, below_first, free_go, div_bad;
	logic                        claim_last, compact_last;
	logic [fspa_pkg::SLOT_W+fspa_pkg::SIZE_W-1:0] goff_prod;
	logic [fspa_pkg::OFF_W-1:0]  goff_calc;

	logic                        ram_we;
	logic [RAM_AW-1:0]           ram_addr;
	logic [fspa_pkg::RAM_W-1:0]  ram_wdata, ram_rdata;
	fspa_pkg::div_req_t          div_req;
	fspa_pkg::div_rsp_t          div_rsp;
	logic                        move_en;
	logic [1:0]                  move_tgt;

	// slot RAM word: {busy, next free slot}
	fspa_ram #(
		.WIDTH(fspa_pkg::RAM_W),
		.DEPTH(fspa_pkg::RAM_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	fspa_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign eff_size = (slot_size_q == '0) ? fspa_pkg::SIZE_W'(1) : slot_size_q;
	assign eff_cap  = (sip_q == '0) ? fspa_pkg::CNT_W'(1) :
		(sip_q > fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS)) ?
		fspa_pkg::CNT_W'(fspa_pkg::MAX_SLOTS) : sip_q;

	assign cur_list = plist_q[part_q];
	assign cur_fc   = fc_q[part_q];
	assign cur_cap  = cap_q[part_q];
	assign cur_fsh  = fsh_q[part_q];
	assign fc_dec   = (cur_fc != '0) ? cur_fc - 1'b1 : '0;
	assign fc_inc   = cur_fc + 1'b1;

	assign not_in_pool = (int'(cmd_q.part_index) >= fspa_pkg::NUM_PARTS) ||
		(cur_list != fspa_pkg::L_PARTIAL && cur_list != fspa_pkg::L_FULL);
	assign below_first  = cmd_q.byte_offset < fso_q;
	assign free_go      = !not_in_pool && !below_first;
	assign div_bad      = (div_rsp.rem != '0) || (div_rsp.quot >= {1'b0, cur_cap});
	assign claim_last   = sweep_q == eff_cap - 1'b1;
	assign compact_last = part_q == fspa_pkg::PART_W'(fspa_pkg::NUM_PARTS - 1);

	assign goff_prod = (fspa_pkg::SLOT_W + fspa_pkg::SIZE_W)'(slot_q) *
		(fspa_pkg::SLOT_W + fspa_pkg::SIZE_W)'(eff_size);
	assign goff_calc = fso_q + goff_prod[fspa_pkg::OFF_W-1:0];

	// lowest unused part
	always_comb begin
		found   = 1'b0;
		claim_p = '0;
		for (int i = fspa_pkg::NUM_PARTS - 1; i >= 0; i--) begin
			if (plist_q[i] == fspa_pkg::L_UNUSED) begin
				found   = 1'b1;
				claim_p = fspa_pkg::PART_W'(i);
			end
		end
	end

	// unlink part_q from its list, then push it on move_tgt
	always_comb begin
		plist_n = plist_q;
		link_n  = link_q;
		lv_n    = lv_q;
		heads_n = heads_q;
		hv_n    = hv_q;
		l0      = plist_q[part_q];
		if (l0 != fspa_pkg::L_UNUSED) begin
			if (hv_q[l0 - 2'd1] && heads_q[l0 - 2'd1] == part_q) begin
				heads_n[l0 - 2'd1] = link_q[part_q];
				hv_n[l0 - 2'd1]    = lv_q[part_q];
			end else if (hv_q[l0 - 2'd1]) begin
				for (int q = 0; q < fspa_pkg::NUM_PARTS; q++) begin
					if (plist_q[q] == l0 && lv_q[q] && link_q[q] == part_q) begin
						link_n[q] = link_q[part_q];
						lv_n[q]   = lv_q[part_q];
					end
				end
			end
		end
		plist_n[part_q]          = move_tgt;
		link_n[part_q]           = heads_n[move_tgt - 2'd1];
		lv_n[part_q]             = hv_n[move_tgt - 2'd1];
		heads_n[move_tgt - 2'd1] = part_q;
		hv_n[move_tgt - 2'd1]    = 1'b1;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fspa_pkg::S_IDLE: begin
				if (start) begin
					state_d = fspa_pkg::S_DISPATCH;
				end
			end
			fspa_pkg::S_DISPATCH: begin
				unique case (cmd_q.action)
					fspa_pkg::ACT_ALLOC: begin
						if (hv_q[fspa_pkg::L_PARTIAL - 2'd1] || hv_q[fspa_pkg::L_EMPTY - 2'd1]) begin
							state_d = fspa_pkg::S_AREAD;
						end else if (found) begin
							state_d = fspa_pkg::S_CLAIM;
						end else begin
							state_d = fspa_pkg::S_RESP;
						end
					end
					fspa_pkg::ACT_FREE:    state_d = free_go ? fspa_pkg::S_DIV : fspa_pkg::S_RESP;
					fspa_pkg::ACT_COMPACT: state_d = fspa_pkg::S_COMPACT;
					default:               state_d = fspa_pkg::S_RESP;
				endcase
			end
			fspa_pkg::S_CLAIM: begin
				if (claim_last) begin
					state_d = fspa_pkg::S_AREAD;
				end
			end
			fspa_pkg::S_AREAD:   state_d = fspa_pkg::S_ACOMMIT;
			fspa_pkg::S_ACOMMIT: state_d = fspa_pkg::S_RESP;
			fspa_pkg::S_DIV: begin
				if (div_rsp.done) begin
					state_d = div_bad ? fspa_pkg::S_RESP : fspa_pkg::S_FREAD;
				end
			end
			fspa_pkg::S_FREAD:   state_d = fspa_pkg::S_FCOMMIT;
			fspa_pkg::S_FCOMMIT: state_d = fspa_pkg::S_RESP;
			fspa_pkg::S_COMPACT: begin
				if (compact_last) begin
					state_d = fspa_pkg::S_RESP;
				end
			end
			fspa_pkg::S_RESP:    state_d = fspa_pkg::S_IDLE;
			default:             state_d = fspa_pkg::S_IDLE;
		endcase
	end

	// RAM, divider and list-move controls
	always_comb begin
		ram_we           = 1'b0;
		ram_addr         = {part_q, slot_q};
		ram_wdata        = '0;
		div_req.start    = 1'b0;
		div_req.dividend = cmd_q.byte_offset - fso_q;
		div_req.divisor  = eff_size;
		move_en          = 1'b0;
		move_tgt         = fspa_pkg::L_EMPTY;
		unique case (state_q)
			fspa_pkg::S_DISPATCH: begin
				div_req.start = (cmd_q.action == fspa_pkg::ACT_FREE) && free_go;
			end
			fspa_pkg::S_CLAIM: begin
				ram_we    = 1'b1;
				ram_addr  = {part_q, sweep_q[fspa_pkg::SLOT_W-1:0]};
				ram_wdata = {1'b0, sweep_q + 1'b1};
				move_en   = claim_last;
			end
			fspa_pkg::S_AREAD: begin
				ram_addr = {part_q, cur_fsh[fspa_pkg::SLOT_W-1:0]};
			end
			fspa_pkg::S_ACOMMIT: begin
				ram_we    = 1'b1;
				ram_wdata = {1'b1, ram_rdata[fspa_pkg::CNT_W-1:0]};
				move_en   = 1'b1;
				move_tgt  = (fc_dec == '0) ? fspa_pkg::L_FULL : fspa_pkg::L_PARTIAL;
			end
			fspa_pkg::S_FCOMMIT: begin
				if (ram_rdata[fspa_pkg::CNT_W]) begin
					ram_we    = 1'b1;
					ram_wdata = {1'b0, (cur_fc != '0) ? cur_fsh : ram_rdata[fspa_pkg::CNT_W-1:0]};
					if (fc_inc >= cur_cap) begin
						move_en  = 1'b1;
						move_tgt = fspa_pkg::L_EMPTY;
					end else if (fc_inc == fspa_pkg::CNT_W'(1)) begin
						move_en  = 1'b1;
						move_tgt = fspa_pkg::L_PARTIAL;
					end
				end
			end
			default: ;
		endcase
	end

	// control state, list membership and counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= fspa_pkg::S_IDLE;
			done_q       <= 1'b0;
			slot_size_q  <= fspa_pkg::SIZE_W'(16);
			fso_q        <= fspa_pkg::OFF_W'(16);
			sip_q        <= fspa_pkg::CNT_W'(255);
			hv_q         <= '0;
			pool_free_q  <= '0;
			pool_total_q <= '0;
			for (int i = 0; i < fspa_pkg::NUM_PARTS; i++) begin
				plist_q[i] <= fspa_pkg::L_UNUSED;
				fc_q[i]    <= '0;
			end
		end else begin
			state_q <= state_d;
			done_q  <= state_q == fspa_pkg::S_RESP;
			if (cfg_we) begin
				unique case (cfg_index)
					fspa_pkg::CFG_SLOT_SIZE:  slot_size_q <= cfg_data;
					fspa_pkg::CFG_FIRST_SLOT: fso_q <= cfg_data[fspa_pkg::OFF_W-1:0];
					fspa_pkg::CFG_SLOTS:      sip_q <= cfg_data[fspa_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (move_en) begin
				plist_q <= plist_n;
				hv_q    <= hv_n;
			end
			unique case (state_q)
				fspa_pkg::S_CLAIM: begin
					if (claim_last) begin
						fc_q[part_q] <= eff_cap;
						pool_free_q  <= pool_free_q + fspa_pkg::POOL_W'(eff_cap);
						pool_total_q <= pool_total_q + fspa_pkg::POOL_W'(eff_cap);
					end
				end
				fspa_pkg::S_ACOMMIT: begin
					fc_q[part_q] <= fc_dec;
					if (pool_free_q != '0) begin
						pool_free_q <= pool_free_q - 1'b1;
					end
				end
				fspa_pkg::S_FCOMMIT: begin
					if (ram_rdata[fspa_pkg::CNT_W]) begin
						fc_q[part_q] <= fc_inc;
						pool_free_q  <= pool_free_q + 1'b1;
					end
				end
				fspa_pkg::S_COMPACT: begin
					if (cur_list == fspa_pkg::L_EMPTY) begin
						plist_q[part_q] <= fspa_pkg::L_UNUSED;
						fc_q[part_q]    <= '0;
						pool_total_q <= (pool_total_q >= fspa_pkg::POOL_W'(cur_cap)) ?
							pool_total_q - fspa_pkg::POOL_W'(cur_cap) : '0;
						pool_free_q  <= (pool_free_q >= fspa_pkg::POOL_W'(cur_fc)) ?
							pool_free_q - fspa_pkg::POOL_W'(cur_fc) : '0;
					end
					if (compact_last) begin
						hv_q[fspa_pkg::L_EMPTY - 2'd1] <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// command, per-part payload and result registers
	always_ff @(posedge clk) begin
		if (state_q == fspa_pkg::S_IDLE && start) begin
			cmd_q    <= cmd;
			part_q   <= cmd.part_index;
			status_q <= fspa_pkg::ST_OK;
			gpart_q  <= '0;
			goff_q   <= '0;
		end
		if (move_en) begin
			heads_q <= heads_n;
			link_q  <= link_n;
			lv_q    <= lv_n;
		end
		unique case (state_q)
			fspa_pkg::S_DISPATCH: begin
				unique case (cmd_q.action)
					fspa_pkg::ACT_ALLOC: begin
						if (hv_q[fspa_pkg::L_PARTIAL - 2'd1]) begin
							part_q <= heads_q[fspa_pkg::L_PARTIAL - 2'd1];
						end else if (hv_q[fspa_pkg::L_EMPTY - 2'd1]) begin
							part_q <= heads_q[fspa_pkg::L_EMPTY - 2'd1];
						end else if (found) begin
							part_q  <= claim_p;
							sweep_q <= '0;
						end else begin
							status_q <= fspa_pkg::ST_NO_SPACE;
						end
					end
					fspa_pkg::ACT_FREE: begin
						if (not_in_pool) begin
							status_q <= fspa_pkg::ST_NOT_IN_POOL;
						end else if (below_first) begin
							status_q <= fspa_pkg::ST_MISALIGNED;
						end
					end
					fspa_pkg::ACT_COMPACT: part_q <= '0;
					default: ;
				endcase
			end
			fspa_pkg::S_CLAIM: begin
				sweep_q <= sweep_q + 1'b1;
				if (claim_last) begin
					cap_q[part_q] <= eff_cap;
					fsh_q[part_q] <= '0;
				end
			end
			fspa_pkg::S_AREAD: slot_q <= cur_fsh[fspa_pkg::SLOT_W-1:0];
			fspa_pkg::S_ACOMMIT: begin
				if (cur_fc > fspa_pkg::CNT_W'(1)) begin
					fsh_q[part_q] <= ram_rdata[fspa_pkg::CNT_W-1:0];
				end
				gpart_q <= part_q;
				goff_q  <= goff_calc;
			end
			fspa_pkg::S_DIV: begin
				if (div_rsp.done) begin
					if (div_bad) begin
						status_q <= fspa_pkg::ST_MISALIGNED;
					end else begin
						slot_q <= div_rsp.quot[fspa_pkg::SLOT_W-1:0];
					end
				end
			end
			fspa_pkg::S_FCOMMIT: begin
				if (ram_rdata[fspa_pkg::CNT_W]) begin
					fsh_q[part_q] <= {1'b0, slot_q};
				end else begin
					status_q <= fspa_pkg::ST_DOUBLE_FREE;
				end
			end
			fspa_pkg::S_COMPACT: part_q <= part_q + 1'b1;
			fspa_pkg::S_RESP: begin
				rsp_q.status       <= status_q;
				rsp_q.given_part   <= gpart_q;
				rsp_q.given_offset <= goff_q;
				rsp_q.free_slots   <= pool_free_q;
				rsp_q.total_slots  <= pool_total_q;
			end
			default: ;
		endcase
	end

	assign busy = state_q != fspa_pkg::S_IDLE;
	assign done = done_q;
	assign rsp  = rsp_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("command transfer did not start work");

	a_free_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		pool_free_q <= pool_total_q)
		else $error("free slot count exceeds owned slot count");

	a_done_after_resp: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q) == fspa_pkg::S_RESP)
		else $error("result strobe without response state");

endmodule

/* sim/tb_fixed_slot_pool_allocator_top.sv */
// Self-checking testbench of the fixed slot pool allocator: directed and random commands against a predictor.
module tb_fixed_slot_pool_allocator_top;

	localparam int WATCHDOG = 20000;
	// action code with no meaning: changes nothing
	localparam logic [1:0] ACT_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic done;
	fspa_pkg::cmd_t cmd = '0;
	fspa_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = fspa_pkg::CFG_SLOT_SIZE;
	logic [fspa_pkg::SIZE_W-1:0] cfg_data = '0;

	fixed_slot_pool_allocator_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	int unsigned m_size, m_first, m_slots;
	logic [1:0] m_list [fspa_pkg::NUM_PARTS];
	int unsigned m_link [fspa_pkg::NUM_PARTS];
	bit m_link_ok [fspa_pkg::NUM_PARTS];
	int unsigned m_head [3];
	bit m_head_ok [3];
	int unsigned m_free [fspa_pkg::NUM_PARTS];
	int unsigned m_cap [fspa_pkg::NUM_PARTS];
	int unsigned m_top [fspa_pkg::NUM_PARTS];
	int unsigned m_next [fspa_pkg::RAM_DEPTH];
	bit m_busy [fspa_pkg::RAM_DEPTH];
	int unsigned m_pool_free, m_pool_total;

	fspa_pkg::cmd_t pending_cmds [$];
	fspa_pkg::rsp_t expected_rsps [$];
	int mismatches = 0;
	int idle_cycles = 0;
	bit stim_done = 0;
	bit no_idle = 0;

	function automatic void list_push(int unsigned p, logic [1:0] l);
		m_link[p] = m_head[l-1];
		m_link_ok[p] = m_head_ok[l-1];
		m_head[l-1] = p;
		m_head_ok[l-1] = 1;
		m_list[p] = l;
	endfunction

	function automatic void list_unlink(int unsigned p);
		logic [1:0] l;
		int unsigned q;
		l = m_list[p];
		if (l == fspa_pkg::L_UNUSED) return;
		if (m_head_ok[l-1] && m_head[l-1] == p) begin
			m_head[l-1] = m_link[p];
			m_head_ok[l-1] = m_link_ok[p];
		end else if (m_head_ok[l-1]) begin
			q = m_head[l-1];
			for (int k = 0; k < fspa_pkg::NUM_PARTS; k++) begin
				if (!m_link_ok[q]) break;
				if (m_link[q] == p) begin
					m_link[q] = m_link[p];
					m_link_ok[q] = m_link_ok[p];
					break;
				end
				q = m_link[q];
			end
		end
		m_list[p] = fspa_pkg::L_UNUSED;
	endfunction

	function automatic int unsigned cur_cap();
		if (m_slots < 1) return 1;
		if (m_slots > fspa_pkg::MAX_SLOTS) return fspa_pkg::MAX_SLOTS;
		return m_slots;
	endfunction

	function automatic int unsigned cur_size();
		return m_size == 0 ? 1 : m_size;
	endfunction

	function automatic bit claim_part();
		int unsigned c;
		c = cur_cap();
		for (int p = 0; p < fspa_pkg::NUM_PARTS; p++) begin
			if (m_list[p] != fspa_pkg::L_UNUSED) continue;
			m_cap[p] = c;
			m_free[p] = c;
			m_top[p] = 0;
			for (int i = 0; i < c; i++) begin
				m_next[p*fspa_pkg::MAX_SLOTS+i] = i + 1;
				m_busy[p*fspa_pkg::MAX_SLOTS+i] = 0;
			end
			m_pool_total += c;
			m_pool_free += c;
			list_push(p, fspa_pkg::L_EMPTY);
			return 1;
		end
		return 0;
	endfunction

	function automatic void pool_reset();
		m_size = 16; m_first = 16; m_slots = 255;
		for (int p = 0; p < fspa_pkg::NUM_PARTS; p++) begin
			m_list[p] = fspa_pkg::L_UNUSED; m_link_ok[p] = 0; m_free[p] = 0; m_cap[p] = 0;
		end
		for (int l = 0; l < 3; l++) m_head_ok[l] = 0;
		m_pool_free = 0; m_pool_total = 0;
	endfunction

	function automatic fspa_pkg::rsp_t pool_step(fspa_pkg::cmd_t c);
		fspa_pkg::rsp_t r;
		int unsigned p, s, sz, d;
		logic [1:0] from;
		r = '0;
		if (c.action == fspa_pkg::ACT_ALLOC) begin
			from = fspa_pkg::L_UNUSED;
			if (m_head_ok[fspa_pkg::L_PARTIAL-1]) from = fspa_pkg::L_PARTIAL;
			else if (m_head_ok[fspa_pkg::L_EMPTY-1] || claim_part()) from = fspa_pkg::L_EMPTY;
			if (from == fspa_pkg::L_UNUSED) r.status = fspa_pkg::ST_NO_SPACE;
			else begin
				p = m_head[from-1];
				s = m_top[p] % fspa_pkg::MAX_SLOTS;
				m_busy[p*fspa_pkg::MAX_SLOTS+s] = 1;
				if (m_free[p] > 1) m_top[p] = m_next[p*fspa_pkg::MAX_SLOTS+s];
				if (m_free[p] > 0) m_free[p]--;
				if (m_pool_free > 0) m_pool_free--;
				list_unlink(p);
				list_push(p, m_free[p] == 0 ? fspa_pkg::L_FULL : fspa_pkg::L_PARTIAL);
				r.status = fspa_pkg::ST_OK;
				r.given_part = fspa_pkg::PART_W'(p);
				r.given_offset = fspa_pkg::OFF_W'(m_first + s * cur_size());
			end
		end else if (c.action == fspa_pkg::ACT_FREE) begin
			p = c.part_index;
			if (m_list[p] != fspa_pkg::L_PARTIAL && m_list[p] != fspa_pkg::L_FULL)
				r.status = fspa_pkg::ST_NOT_IN_POOL;
			else begin
				sz = cur_size();
				d = c.byte_offset - m_first;
				if (c.byte_offset < m_first || d % sz != 0 || d / sz >= m_cap[p])
					r.status = fspa_pkg::ST_MISALIGNED;
				else begin
					s = d / sz;
					if (!m_busy[p*fspa_pkg::MAX_SLOTS+s]) r.status = fspa_pkg::ST_DOUBLE_FREE;
					else begin
						m_busy[p*fspa_pkg::MAX_SLOTS+s] = 0;
						if (m_free[p] > 0) m_next[p*fspa_pkg::MAX_SLOTS+s] = m_top[p];
						m_top[p] = s;
						m_free[p]++;
						m_pool_free++;
						if (m_free[p] >= m_cap[p]) begin
							list_unlink(p); list_push(p, fspa_pkg::L_EMPTY);
						end else if (m_free[p] == 1) begin
							list_unlink(p); list_push(p, fspa_pkg::L_PARTIAL);
						end
					end
				end
			end
		end else if (c.action == fspa_pkg::ACT_COMPACT) begin
			for (int q = 0; q < fspa_pkg::NUM_PARTS; q++) begin
				if (m_list[q] != fspa_pkg::L_EMPTY) continue;
				m_list[q] = fspa_pkg::L_UNUSED;
				m_pool_total = m_pool_total >= m_cap[q] ? m_pool_total - m_cap[q] : 0;
				m_pool_free = m_pool_free >= m_free[q] ? m_pool_free - m_free[q] : 0;
				m_free[q] = 0;
			end
			m_head_ok[fspa_pkg::L_EMPTY-1] = 0;
			m_head[fspa_pkg::L_EMPTY-1] = 0;
		end
		r.free_slots = m_pool_free[fspa_pkg::POOL_W-1:0];
		r.total_slots = m_pool_total[fspa_pkg::POOL_W-1:0];
		return r;
	endfunction

	// driver: start stays high across back-to-back transfers
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_rsps.push_back(pool_step(cmd));
			end
			if (!(start && busy)) begin
				if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 37)) begin
					cmd <= pending_cmds.pop_front();
					start <= 1'b1;
				end else
					start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		fspa_pkg::rsp_t e;
		if (arst_n) begin
			if (done || (start && !busy))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (done) begin
				if (expected_rsps.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result %p", rsp);
				end else begin
					e = expected_rsps.pop_front();
					if (rsp !== e) begin
						mismatches++;
						if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, rsp);
					end
				end
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("fixed_slot_pool_allocator_top test failed");
				$finish;
			end
		end
	end

	function automatic fspa_pkg::cmd_t mk(logic [1:0] a, int unsigned p, int unsigned o);
		fspa_pkg::cmd_t c;
		c.action = a;
		c.part_index = fspa_pkg::PART_W'(p);
		c.byte_offset = fspa_pkg::OFF_W'(o);
		return c;
	endfunction

	task automatic drain();
		wait (pending_cmds.size() == 0);
		@(posedge clk);
		while (start || busy || expected_rsps.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned v);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= fspa_pkg::SIZE_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == fspa_pkg::CFG_SLOT_SIZE) m_size = v & 13'h1fff;
		else if (idx == fspa_pkg::CFG_FIRST_SLOT) m_first = v & 12'hfff;
		else m_slots = v & 11'h7ff;
	endtask

	// allocs and aligned frees on parts 0 to 3, plus random frees, compacts and no-ops
	task automatic random_phase(int n, int unsigned sz, int unsigned first, int unsigned cap);
		int unsigned r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) pending_cmds.push_back(mk(fspa_pkg::ACT_ALLOC, $urandom, $urandom));
			else if (r < 80) pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, $urandom_range(3),
				first + sz * $urandom_range(cap > 0 ? cap - 1 : 0)));
			else if (r < 90) pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, $urandom, $urandom));
			else if (r < 95) pending_cmds.push_back(mk(fspa_pkg::ACT_COMPACT, $urandom, $urandom));
			else pending_cmds.push_back(mk(ACT_NONE, $urandom, $urandom));
		end
	endtask

	initial begin
		pool_reset();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		// directed: errors on empty pool, allocs, frees, double free, misaligned
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 16));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 15, 4095));
		pending_cmds.push_back(mk(ACT_NONE, 15, 4095));
		pending_cmds.push_back(mk(fspa_pkg::ACT_COMPACT, 0, 0));
		pending_cmds.push_back(mk(fspa_pkg::ACT_ALLOC, 0, 0));
		pending_cmds.push_back(mk(fspa_pkg::ACT_ALLOC, 15, 4095));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 0));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 17));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 16 + 16 * 255));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 48));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 32));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 32));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 0, 16));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 1, 16));
		pending_cmds.push_back(mk(fspa_pkg::ACT_COMPACT, 0, 0));
		drain();
		// single-slot parts, tiny slot size, up to out of space
		write_reg(fspa_pkg::CFG_SLOTS, 0);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 0);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 0);
		for (int i = 0; i < 18; i++) pending_cmds.push_back(mk(fspa_pkg::ACT_ALLOC, 0, 0));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 3, 0));
		pending_cmds.push_back(mk(fspa_pkg::ACT_FREE, 3, 1));
		pending_cmds.push_back(mk(fspa_pkg::ACT_COMPACT, 0, 0));
		random_phase(250, 1, 0, 1);
		drain();
		no_idle = 1;
		write_reg(fspa_pkg::CFG_SLOTS, 4);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 4);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 4095);
		random_phase(300, 4, 4095, 4);
		drain();
		no_idle = 0;
		write_reg(fspa_pkg::CFG_SLOTS, 6);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 24);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 8);
		random_phase(500, 24, 8, 6);
		drain();
		// max slot size with the slot count capped, then large slots with few per part, then small slots
		write_reg(fspa_pkg::CFG_SLOTS, 2047);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 8191);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 12);
		random_phase(150, 8191, 12, 1);
		drain();
		write_reg(fspa_pkg::CFG_SLOTS, 3);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 4096);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 0);
		random_phase(250, 4096, 0, 1);
		drain();
		write_reg(fspa_pkg::CFG_SLOTS, 1024);
		write_reg(fspa_pkg::CFG_SLOT_SIZE, 4);
		write_reg(fspa_pkg::CFG_FIRST_SLOT, 0);
		random_phase(250, 4, 0, 1024);
		drain();
		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("fixed_slot_pool_allocator_top test passed");
		else
			$display("fixed_slot_pool_allocator_top test failed");
		$finish;
	end
endmodule
